// ===== sv/fsgs_pkg.sv =====
// Shared types, opcodes and defaults for the falling-sand grid block.
`timescale 1ns / 1ps

package fsgs_pkg;

	localparam int GRID_COLUMNS_DEF = 64;
	localparam int GRID_ROWS_DEF    = 64;
	localparam int CELL_PIXELS_DEF  = 8;

	localparam int PIX_W   = 11;
	localparam int COLOR_W = 8;

	typedef enum logic [1:0] {
		OP_FILL  = 2'd0,
		OP_STEP  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_WIPE,
		ST_LOC,
		ST_FILL,
		ST_RD_ISSUE,
		ST_RD_DATA,
		ST_SCAN_HERE,
		ST_SCAN_TEST,
		ST_TEST_B,
		ST_TEST_L,
		ST_TEST_R,
		ST_MOVE_DST,
		ST_MOVE_SRC
	} state_t;

	typedef struct packed {
		logic load;
		logic locate;
		logic wipe_init;
		logic wipe_wr;
		logic fill_wr;
		logic rd_cell;
		logic scan_init;
		logic rd_here;
		logic rd_below;
		logic rd_left;
		logic rd_right;
		logic dst_b;
		logic dst_l;
		logic dst_r;
		logic mv_dst;
		logic mv_src;
		logic advance;
		logic res_range;
		logic res_read;
		logic res_zero;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic occ;
		logic col_first;
		logic col_last;
		logic scan_last;
		logic wipe_last;
	} status_t;

endpackage

// ===== sv/fsgs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fsgs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/fsgs_datapath.sv =====
// Datapath: coordinate divider, cell addressing, grid memories and result registers.
`timescale 1ns / 1ps

module fsgs_datapath #(
	parameter int GRID_COLUMNS = fsgs_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_ROWS    = fsgs_pkg::GRID_ROWS_DEF,
	parameter int CELL_PIXELS  = fsgs_pkg::CELL_PIXELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fsgs_pkg::cmd_t                cmd,
	output fsgs_pkg::status_t             sts,
	input  logic [fsgs_pkg::PIX_W-1:0]    pixel_x,
	input  logic [fsgs_pkg::PIX_W-1:0]    pixel_y,
	input  logic [fsgs_pkg::COLOR_W-1:0]  fill_red,
	input  logic [fsgs_pkg::COLOR_W-1:0]  fill_green,
	input  logic [fsgs_pkg::COLOR_W-1:0]  fill_blue,
	output logic                          occupied,
	output logic [fsgs_pkg::COLOR_W-1:0]  cell_red,
	output logic [fsgs_pkg::COLOR_W-1:0]  cell_green,
	output logic [fsgs_pkg::COLOR_W-1:0]  cell_blue,
	output logic                          in_range,
	output logic                          done
);

	import fsgs_pkg::*;

	localparam int CELLS    = GRID_COLUMNS * GRID_ROWS;
	localparam int AW       = $clog2(CELLS);
	localparam int XW       = $clog2(GRID_COLUMNS);
	localparam int YW       = $clog2(GRID_ROWS);
	localparam int RGB_W    = 3 * COLOR_W;
	localparam int START    = (GRID_ROWS - 2) * GRID_COLUMNS;
	localparam int RECIP_SH = PIX_W + $clog2(CELL_PIXELS);
	localparam int RECIP_W  = PIX_W + 1;
	localparam int PROD_W   = RECIP_SH + PIX_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((1 << RECIP_SH) + CELL_PIXELS - 1) / CELL_PIXELS);

	// divide by CELL_PIXELS as a reciprocal multiply, exact over the whole pixel range
	logic [PIX_W-1:0]  qx_q, qy_q;
	logic [PROD_W-1:0] prod_x, prod_y;

	assign prod_x = PROD_W'(pixel_x) * PROD_W'(RECIP);
	assign prod_y = PROD_W'(pixel_y) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			qx_q <= prod_x[RECIP_SH +: PIX_W];
			qy_q <= prod_y[RECIP_SH +: PIX_W];
		end
	end

	// cell location
	logic [RGB_W-1:0] rgb_q;
	logic             inr_q;
	logic [AW-1:0]    idx_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rgb_q <= {fill_red, fill_green, fill_blue};
		end
		if (cmd.locate) begin
			inr_q <= (qx_q < PIX_W'(GRID_COLUMNS)) && (qy_q < PIX_W'(GRID_ROWS));
			idx_q <= AW'(qy_q[YW-1:0]) * AW'(GRID_COLUMNS) + AW'(qx_q[XW-1:0]);
		end
	end

	// sweep position for step ticks; walks rows bottom-up, columns left to right
	logic [AW-1:0] here_q, dst_q, below, left, right;
	logic [XW-1:0] col_q;
	logic          col_last;

	assign below    = here_q + AW'(GRID_COLUMNS);
	assign left     = below - AW'(1);
	assign right    = below + AW'(1);
	assign col_last = col_q == XW'(GRID_COLUMNS - 1);

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			here_q <= AW'(START);
			col_q  <= '0;
		end else if (cmd.advance) begin
			if (col_last) begin
				here_q <= here_q - AW'(2 * GRID_COLUMNS - 1);
				col_q  <= '0;
			end else begin
				here_q <= here_q + AW'(1);
				col_q  <= col_q + XW'(1);
			end
		end
		if (cmd.dst_b) begin
			dst_q <= below;
		end else if (cmd.dst_l) begin
			dst_q <= left;
		end else if (cmd.dst_r) begin
			dst_q <= right;
		end
	end

	// clearing sweep
	logic [AW-1:0] wipe_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_q <= '0;
		end else if (cmd.wipe_init) begin
			wipe_q <= '0;
		end else if (cmd.wipe_wr) begin
			wipe_q <= wipe_q + AW'(1);
		end
	end

	// grid memories
	logic             occ_we, occ_wdata, occ_re, occ_rd;
	logic [AW-1:0]    occ_waddr, occ_raddr;
	logic             col_we, col_re;
	logic [AW-1:0]    col_waddr, col_raddr;
	logic [RGB_W-1:0] col_wdata, col_rd;
	logic             fill_go;

	assign fill_go = cmd.fill_wr & inr_q;

	always_comb begin
		occ_we    = cmd.wipe_wr | fill_go | cmd.mv_dst | cmd.mv_src;
		occ_wdata = fill_go | cmd.mv_dst;
		if (cmd.wipe_wr) begin
			occ_waddr = wipe_q;
		end else if (cmd.fill_wr) begin
			occ_waddr = idx_q;
		end else if (cmd.mv_dst) begin
			occ_waddr = dst_q;
		end else begin
			occ_waddr = here_q;
		end

		occ_re = cmd.rd_cell | cmd.rd_here | cmd.rd_below | cmd.rd_left | cmd.rd_right;
		if (cmd.rd_cell) begin
			occ_raddr = idx_q;
		end else if (cmd.rd_below) begin
			occ_raddr = below;
		end else if (cmd.rd_left) begin
			occ_raddr = left;
		end else if (cmd.rd_right) begin
			occ_raddr = right;
		end else begin
			occ_raddr = here_q;
		end

		// color read data is held from the read of the source cell until the move
		col_we    = fill_go | cmd.mv_dst;
		col_waddr = cmd.mv_dst ? dst_q : idx_q;
		col_wdata = cmd.mv_dst ? col_rd : rgb_q;
		col_re    = cmd.rd_cell | cmd.rd_here;
		col_raddr = cmd.rd_cell ? idx_q : here_q;
	end

	fsgs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_occ_ram (
		.clk   (clk),
		.we    (occ_we),
		.waddr (occ_waddr),
		.wdata (occ_wdata),
		.re    (occ_re),
		.raddr (occ_raddr),
		.rdata (occ_rd)
	);

	fsgs_ram #(.WIDTH(RGB_W), .DEPTH(CELLS)) u_color_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (col_waddr),
		.wdata (col_wdata),
		.re    (col_re),
		.raddr (col_raddr),
		.rdata (col_rd)
	);

	// result word
	logic done_q, occupied_q, res_in_range_q;
	logic [COLOR_W-1:0] red_q, green_q, blue_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.res_range | cmd.res_read | cmd.res_zero;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_read) begin
			occupied_q     <= occ_rd;
			red_q          <= occ_rd ? col_rd[3*COLOR_W-1:2*COLOR_W] : '0;
			green_q        <= occ_rd ? col_rd[2*COLOR_W-1:COLOR_W] : '0;
			blue_q         <= occ_rd ? col_rd[COLOR_W-1:0] : '0;
			res_in_range_q <= 1'b1;
		end else if (cmd.res_range | cmd.res_zero) begin
			occupied_q     <= 1'b0;
			red_q          <= '0;
			green_q        <= '0;
			blue_q         <= '0;
			res_in_range_q <= cmd.res_range & inr_q;
		end
	end

	assign occupied   = occupied_q;
	assign cell_red   = red_q;
	assign cell_green = green_q;
	assign cell_blue  = blue_q;
	assign in_range   = res_in_range_q;
	assign done       = done_q;

	assign sts.in_range  = inr_q;
	assign sts.occ       = occ_rd;
	assign sts.col_first = col_q == '0;
	assign sts.col_last  = col_last;
	assign sts.scan_last = here_q == AW'(GRID_COLUMNS - 1);
	assign sts.wipe_last = wipe_q == AW'(CELLS - 1);

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.wipe_wr, cmd.fill_wr, cmd.mv_dst, cmd.mv_src}) <= 1)
		else $error("more than one occupancy write source");

	a_move_target: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mv_dst |-> dst_q != here_q)
		else $error("grain moved onto its own cell");

	a_read_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && occupied_q |-> res_in_range_q)
		else $error("occupied result outside the grid");

endmodule

// ===== sv/fsgs_ctrl.sv =====
// Controller state machine: sequences fill, read, clear and the gravity sweep.
`timescale 1ns / 1ps

module fsgs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  fsgs_pkg::op_t     opcode,
	input  fsgs_pkg::status_t sts,
	output fsgs_pkg::cmd_t    cmd,
	output logic              busy
);

	import fsgs_pkg::*;

	state_t state_q, state_d;
	op_t    op_q;
	logic   cell_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			op_q    <= OP_FILL;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				op_q <= opcode;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cell_done = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.wipe_wr = 1'b1;
				if (sts.wipe_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (opcode) inside
						OP_FILL, OP_READ: state_d = ST_LOC;
						OP_STEP: begin
							cmd.scan_init = 1'b1;
							state_d       = ST_SCAN_HERE;
						end
						OP_CLEAR: begin
							cmd.wipe_init = 1'b1;
							state_d       = ST_WIPE;
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_WIPE: begin
				cmd.wipe_wr = 1'b1;
				if (sts.wipe_last) begin
					cmd.res_zero = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_LOC: begin
				cmd.locate = 1'b1;
				state_d    = (op_q == OP_FILL) ? ST_FILL : ST_RD_ISSUE;
			end
			ST_FILL: begin
				cmd.fill_wr   = 1'b1;
				cmd.res_range = 1'b1;
				state_d       = ST_IDLE;
			end
			ST_RD_ISSUE: begin
				if (sts.in_range) begin
					cmd.rd_cell = 1'b1;
					state_d     = ST_RD_DATA;
				end else begin
					cmd.res_range = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			ST_RD_DATA: begin
				cmd.res_read = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_SCAN_HERE: begin
				cmd.rd_here = 1'b1;
				state_d     = ST_SCAN_TEST;
			end
			ST_SCAN_TEST: begin
				if (sts.occ) begin
					cmd.rd_below = 1'b1;
					state_d      = ST_TEST_B;
				end else begin
					cell_done = 1'b1;
				end
			end
			ST_TEST_B: begin
				if (!sts.occ) begin
					cmd.dst_b = 1'b1;
					state_d   = ST_MOVE_DST;
				end else if (!sts.col_first) begin
					cmd.rd_left = 1'b1;
					state_d     = ST_TEST_L;
				end else if (!sts.col_last) begin
					cmd.rd_right = 1'b1;
					state_d      = ST_TEST_R;
				end else begin
					cell_done = 1'b1;
				end
			end
			ST_TEST_L: begin
				if (!sts.occ) begin
					cmd.dst_l = 1'b1;
					state_d   = ST_MOVE_DST;
				end else if (!sts.col_last) begin
					cmd.rd_right = 1'b1;
					state_d      = ST_TEST_R;
				end else begin
					cell_done = 1'b1;
				end
			end
			ST_TEST_R: begin
				if (!sts.occ) begin
					cmd.dst_r = 1'b1;
					state_d   = ST_MOVE_DST;
				end else begin
					cell_done = 1'b1;
				end
			end
			ST_MOVE_DST: begin
				cmd.mv_dst = 1'b1;
				state_d    = ST_MOVE_SRC;
			end
			ST_MOVE_SRC: begin
				cmd.mv_src = 1'b1;
				cell_done  = 1'b1;
			end
			default: state_d = ST_IDLE;
		endcase

		// last cell of the sweep is the rightmost cell of row 0
		if (cell_done) begin
			if (sts.scan_last) begin
				cmd.res_zero = 1'b1;
				state_d      = ST_IDLE;
			end else begin
				cmd.advance = 1'b1;
				state_d     = ST_SCAN_HERE;
			end
		end
	end

	assign busy = state_q != ST_IDLE;

endmodule

// ===== sv/falling_sand_grid_step_top.sv =====
// Falling-sand grid: one command in (fill, step, clear, read), one result word out per command;
// busy is high from acceptance until the result, and for a clearing pass over every cell after
// reset. The result word appears for exactly one cycle with done and cannot be held off by the
// receiver. The pixel-to-cell divide is a constant reciprocal multiply done as the word is taken.
// Clear wipes every cell in turn; a step tick visits (GRID_ROWS-1)*GRID_COLUMNS cells, testing the
// cell below each grain, then below-left, then below-right, one read at a time through the single
// read port of the occupancy memory.
`timescale 1ns / 1ps

module falling_sand_grid_step_top #(
	parameter int GRID_COLUMNS = fsgs_pkg::GRID_COLUMNS_DEF,
	parameter int GRID_ROWS    = fsgs_pkg::GRID_ROWS_DEF,
	parameter int CELL_PIXELS  = fsgs_pkg::CELL_PIXELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic [fsgs_pkg::PIX_W-1:0]    pixel_x,
	input  logic [fsgs_pkg::PIX_W-1:0]    pixel_y,
	input  logic [fsgs_pkg::COLOR_W-1:0]  fill_red,
	input  logic [fsgs_pkg::COLOR_W-1:0]  fill_green,
	input  logic [fsgs_pkg::COLOR_W-1:0]  fill_blue,
	output logic                          done,
	output logic                          occupied,
	output logic [fsgs_pkg::COLOR_W-1:0]  cell_red,
	output logic [fsgs_pkg::COLOR_W-1:0]  cell_green,
	output logic [fsgs_pkg::COLOR_W-1:0]  cell_blue,
	output logic                          in_range
);

	import fsgs_pkg::*;

	cmd_t    cmd;
	status_t sts;

	fsgs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (op_t'(opcode)),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	fsgs_datapath #(
		.GRID_COLUMNS (GRID_COLUMNS),
		.GRID_ROWS    (GRID_ROWS),
		.CELL_PIXELS  (CELL_PIXELS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.fill_red   (fill_red),
		.fill_green (fill_green),
		.fill_blue  (fill_blue),
		.occupied   (occupied),
		.cell_red   (cell_red),
		.cell_green (cell_green),
		.cell_blue  (cell_blue),
		.in_range   (in_range),
		.done       (done)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

endmodule

// ===== tb/sv/falling_sand_grid_step_top_tb.sv =====
// Self-checking testbench for the falling-sand grid block: directed table, then random commands.
`timescale 1ns / 1ps

module falling_sand_grid_step_top_tb;
	import fsgs_pkg::*;

	localparam int COLS     = GRID_COLUMNS_DEF;
	localparam int ROWS     = GRID_ROWS_DEF;
	localparam int CELL_PX  = CELL_PIXELS_DEF;
	localparam int CELLS    = COLS * ROWS;
	localparam int RAND_N   = 76;
	localparam int DIR_N    = 24;

	typedef struct packed {
		logic                occupied;
		logic [COLOR_W-1:0]  red;
		logic [COLOR_W-1:0]  green;
		logic [COLOR_W-1:0]  blue;
		logic                in_range;
	} result_t;

	typedef struct packed {
		op_t                 op;
		logic [PIX_W-1:0]    px;
		logic [PIX_W-1:0]    py;
		logic [COLOR_W-1:0]  r;
		logic [COLOR_W-1:0]  g;
		logic [COLOR_W-1:0]  b;
		logic                typed;
		result_t             want;
	} cmd_row_t;

	localparam result_t NO_WORD   = '0;
	localparam result_t EMPTY_IN  = '{1'b0, 8'h00, 8'h00, 8'h00, 1'b1};
	localparam result_t WHITE_IN  = '{1'b1, 8'hff, 8'hff, 8'hff, 1'b1};
	localparam result_t BLACK_IN  = '{1'b1, 8'h00, 8'h00, 8'h00, 1'b1};

	// typed rows: after reset, extremes, clear; the rest go through the grid predictor
	cmd_row_t directed_rows [DIR_N] = '{
		'{OP_READ,  11'd0,    11'd0,    8'h00, 8'h00, 8'h00, 1'b1, EMPTY_IN},
		'{OP_READ,  11'd2047, 11'd2047, 8'hff, 8'hff, 8'hff, 1'b1, NO_WORD},
		'{OP_FILL,  11'd2047, 11'd0,    8'haa, 8'h55, 8'haa, 1'b1, NO_WORD},
		'{OP_FILL,  11'd0,    11'd2047, 8'h55, 8'haa, 8'h55, 1'b1, NO_WORD},
		'{OP_FILL,  11'd512,  11'd7,    8'h11, 8'h22, 8'h33, 1'b1, NO_WORD},
		'{OP_FILL,  11'd511,  11'd511,  8'hff, 8'hff, 8'hff, 1'b1, EMPTY_IN},
		'{OP_READ,  11'd511,  11'd511,  8'h00, 8'h00, 8'h00, 1'b1, WHITE_IN},
		'{OP_FILL,  11'd0,    11'd0,    8'h00, 8'h00, 8'h00, 1'b1, EMPTY_IN},
		'{OP_READ,  11'd7,    11'd7,    8'h00, 8'h00, 8'h00, 1'b1, BLACK_IN},
		'{OP_FILL,  11'd0,    11'd504,  8'h12, 8'h34, 8'h56, 1'b0, NO_WORD},
		'{OP_FILL,  11'd3,    11'd496,  8'h9a, 8'hbc, 8'hde, 1'b0, NO_WORD},
		'{OP_FILL,  11'd504,  11'd496,  8'h01, 8'h80, 8'hfe, 1'b0, NO_WORD},
		'{OP_FILL,  11'd80,   11'd504,  8'h3c, 8'hc3, 8'h5a, 1'b0, NO_WORD},
		'{OP_FILL,  11'd87,   11'd503,  8'ha5, 8'h0f, 8'hf0, 1'b0, NO_WORD},
		'{OP_STEP,  11'd1365, 11'd682,  8'h5a, 8'ha5, 8'h0f, 1'b1, NO_WORD},
		'{OP_READ,  11'd8,    11'd504,  8'h00, 8'h00, 8'h00, 1'b0, NO_WORD},
		'{OP_READ,  11'd496,  11'd504,  8'h00, 8'h00, 8'h00, 1'b0, NO_WORD},
		'{OP_READ,  11'd72,   11'd504,  8'h00, 8'h00, 8'h00, 1'b0, NO_WORD},
		'{OP_READ,  11'd0,    11'd8,    8'h00, 8'h00, 8'h00, 1'b0, NO_WORD},
		'{OP_READ,  11'd511,  11'd511,  8'h00, 8'h00, 8'h00, 1'b0, NO_WORD},
		'{OP_CLEAR, 11'd682,  11'd1365, 8'hc3, 8'h3c, 8'hf0, 1'b1, NO_WORD},
		'{OP_READ,  11'd511,  11'd511,  8'h00, 8'h00, 8'h00, 1'b1, EMPTY_IN},
		'{OP_READ,  11'd0,    11'd504,  8'h00, 8'h00, 8'h00, 1'b1, EMPTY_IN},
		'{OP_READ,  11'd1023, 11'd2047, 8'h00, 8'h00, 8'h00, 1'b1, NO_WORD}
	};

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [1:0]          opcode;
	logic [PIX_W-1:0]    pixel_x;
	logic [PIX_W-1:0]    pixel_y;
	logic [COLOR_W-1:0]  fill_red;
	logic [COLOR_W-1:0]  fill_green;
	logic [COLOR_W-1:0]  fill_blue;
	logic                done;
	logic                occupied;
	logic [COLOR_W-1:0]  cell_red;
	logic [COLOR_W-1:0]  cell_green;
	logic [COLOR_W-1:0]  cell_blue;
	logic                in_range;

	bit                  grid_occ [CELLS];
	logic [23:0]         grid_rgb [CELLS];
	result_t             pending_words [$];

	int err_count;
	int n_checked;
	int n_fill, n_step, n_clear, n_read, n_hit, n_outside;

	falling_sand_grid_step_top #(
		.GRID_COLUMNS(COLS),
		.GRID_ROWS(ROWS),
		.CELL_PIXELS(CELL_PX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.opcode(opcode),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.fill_red(fill_red),
		.fill_green(fill_green),
		.fill_blue(fill_blue),
		.done(done),
		.occupied(occupied),
		.cell_red(cell_red),
		.cell_green(cell_green),
		.cell_blue(cell_blue),
		.in_range(in_range)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic flag_mismatch(input string msg);
		$display("%0t ns  MISMATCH: %s", $time, msg);
		err_count++;
	endtask

	function automatic bit cell_index(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
			output int idx);
		int cx;
		int cy;
		cx = int'(px) / CELL_PX;
		cy = int'(py) / CELL_PX;
		idx = cy * COLS + cx;
		return (cx < COLS) && (cy < ROWS);
	endfunction

	function automatic void shift_grain(input int src, input int dst);
		grid_occ[dst] = 1'b1;
		grid_rgb[dst] = grid_rgb[src];
		grid_occ[src] = 1'b0;
	endfunction

	// one gravity tick: bottom-up, left to right, in place
	function automatic void settle_grains();
		int r;
		int c;
		int at;
		int dn;
		for (r = ROWS - 2; r >= 0; r--) begin
			for (c = 0; c < COLS; c++) begin
				at = r * COLS + c;
				dn = at + COLS;
				if (!grid_occ[at])
					continue;
				if (!grid_occ[dn])
					shift_grain(at, dn);
				else if (c > 0 && !grid_occ[dn - 1])
					shift_grain(at, dn - 1);
				else if (c < COLS - 1 && !grid_occ[dn + 1])
					shift_grain(at, dn + 1);
			end
		end
	endfunction

	task automatic apply_to_grid(input op_t op, input logic [PIX_W-1:0] px,
			input logic [PIX_W-1:0] py, input logic [23:0] rgb, output result_t word);
		int idx;
		bit hit;
		word = '0;
		hit = cell_index(px, py, idx);
		case (op)
			OP_FILL: begin
				n_fill++;
				if (hit) begin
					grid_occ[idx] = 1'b1;
					grid_rgb[idx] = rgb;
					word.in_range = 1'b1;
				end else
					n_outside++;
			end
			OP_STEP: begin
				n_step++;
				settle_grains();
			end
			OP_CLEAR: begin
				n_clear++;
				for (int k = 0; k < CELLS; k++)
					grid_occ[k] = 1'b0;
			end
			default: begin
				n_read++;
				if (hit) begin
					word.in_range = 1'b1;
					if (grid_occ[idx]) begin
						n_hit++;
						word.occupied = 1'b1;
						{word.red, word.green, word.blue} = grid_rgb[idx];
					end
				end else
					n_outside++;
			end
		endcase
	endtask

	// drive one command word, wait for it to be taken, queue its expected result
	task automatic issue(input op_t op, input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py,
			input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
			input logic [COLOR_W-1:0] b, input logic typed, input result_t want);
		result_t predicted;
		@(negedge clk);
		start      <= 1'b1;
		opcode     <= op;
		pixel_x    <= px;
		pixel_y    <= py;
		fill_red   <= r;
		fill_green <= g;
		fill_blue  <= b;
		do
			@(posedge clk);
		while (busy);
		apply_to_grid(op, px, py, {r, g, b}, predicted);
		pending_words.push_back(typed ? want : predicted);
	endtask

	task automatic idle_gap(input bit allow);
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		if (!allow || roll < 40)
			gap = 0;
		else if (roll < 85)
			gap = $urandom_range(1, 3);
		else if (roll < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 60);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
	endtask

	// one pixel coordinate inside a 4-cell span starting at cell base (base_c for x, base_r for y)
	function automatic logic [PIX_W-1:0] window_px(input int base);
		return PIX_W'((base + $urandom_range(0, 3)) * CELL_PX + $urandom_range(0, CELL_PX - 1));
	endfunction

	always @(posedge clk) begin : result_check
		result_t got;
		result_t want;
		if (arst_n && done) begin
			got = '{occupied, cell_red, cell_green, cell_blue, in_range};
			if (pending_words.size() == 0)
				flag_mismatch("result word with no command pending");
			else begin
				want = pending_words.pop_front();
				n_checked++;
				if (got.occupied !== want.occupied)
					flag_mismatch($sformatf("occupied %b, want %b", got.occupied, want.occupied));
				if (got.red !== want.red)
					flag_mismatch($sformatf("cell_red %h, want %h", got.red, want.red));
				if (got.green !== want.green)
					flag_mismatch($sformatf("cell_green %h, want %h", got.green, want.green));
				if (got.blue !== want.blue)
					flag_mismatch($sformatf("cell_blue %h, want %h", got.blue, want.blue));
				if (got.in_range !== want.in_range)
					flag_mismatch($sformatf("in_range %b, want %b", got.in_range, want.in_range));
			end
		end
	end

	initial begin
		int n;
		int roll;
		int base_c;
		int base_r;
		op_t op;
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] py;

		arst_n     = 1'b0;
		start      = 1'b0;
		opcode     = OP_READ;
		pixel_x    = '0;
		pixel_y    = '0;
		fill_red   = '0;
		fill_green = '0;
		fill_blue  = '0;
		base_c     = 0;
		base_r     = ROWS - 4;
		for (int k = 0; k < CELLS; k++) begin
			grid_occ[k] = 1'b0;
			grid_rgb[k] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_N; i++) begin
			issue(directed_rows[i].op, directed_rows[i].px, directed_rows[i].py,
				directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
				directed_rows[i].typed, directed_rows[i].want);
			idle_gap(1'b1);
		end
		drain_results();

		for (n = 0; n < RAND_N; n++) begin
			// new focus window every 20 words, mostly at the floor and often on an edge
			if (n % 20 == 0) begin
				roll = $urandom_range(0, 3);
				base_c = (roll == 0) ? 0 : (roll == 1) ? COLS - 4 : $urandom_range(0, COLS - 4);
				base_r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ROWS - 4) : ROWS - 4;
			end
			if (n == 50)
				drain_results();
			roll = $urandom_range(0, 99);
			if (roll < 45)
				op = OP_FILL;
			else if (roll < 57)
				op = OP_STEP;
			else if (roll < 60)
				op = OP_CLEAR;
			else
				op = OP_READ;
			if ($urandom_range(0, 99) < 75) begin
				px = window_px(base_c);
				py = window_px(base_r);
			end else begin
				px = PIX_W'($urandom_range(0, 2047));
				py = PIX_W'($urandom_range(0, 2047));
			end
			issue(op, px, py, COLOR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 255)),
				COLOR_W'($urandom_range(0, 255)), 1'b0, NO_WORD);
			// back-to-back stretch
			idle_gap(!(n >= 60 && n < 80));
		end

		drain_results();
		repeat (40) @(posedge clk);

		$display("Ran %0d fills, %0d steps, %0d clears, %0d reads (%0d on sand, %0d off grid)",
			n_fill, n_step, n_clear, n_read, n_hit, n_outside);
		$display("%0d result words checked, %0d mismatches", n_checked, err_count);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// worst case is every word a full step tick; this is several times that
	initial begin
		#300_000_000;
		$display("Timeout: %0d result words still pending", pending_words.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
